// ===== hw/rtl/csim_pkg.sv =====
package csim_pkg;

	// vector length limit and datapath widths
	localparam int MAX_LENGTH = 4096;
	localparam int ELEM_W     = 16;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int SUM_W      = 48;
	localparam int RT_W       = SUM_W / 2;
	localparam int REM_W      = RT_W + 3;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 2);
	localparam int SIM_W      = 16;
	localparam int FRAC_W     = 14;
	localparam int Q_W        = FRAC_W + 1;
	localparam int DIV_W      = SUM_W + 1;
	localparam int STEP_W     = $clog2(RT_W);

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [Q_W-1:0] SIM_ONE = Q_W'(1 << FRAC_W);

	// finished sums of one vector pair
	typedef struct packed {
		logic signed [SUM_W-1:0] dot;
		logic [SUM_W-1:0]        norm_a;
		logic [SUM_W-1:0]        norm_b;
		logic                    too_long;
	} job_t;

	// partial remainder and root of the digit-by-digit square root
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [RT_W-1:0]  root;
	} sqrt_t;

	// one root bit from the next two radicand bits
	function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] pair);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] trial;
		sqrt_t            nxt;
		r     = {cur.rem[REM_W-3:0], pair};
		trial = REM_W'({cur.root, 2'b01});
		if (r >= trial) begin
			nxt.rem  = r - trial;
			nxt.root = {cur.root[RT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = r;
			nxt.root = {cur.root[RT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ===== hw/rtl/csim_if.sv =====
// element pair channel
interface csim_in_if;
	import csim_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] elem_a;
	logic signed [ELEM_W-1:0] elem_b;
	logic                     last;
	modport source (output valid, elem_a, elem_b, last, input ready);
	modport sink (input valid, elem_a, elem_b, last, output ready);
endinterface

// similarity result channel
interface csim_out_if;
	import csim_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SIM_W-1:0] similarity;
	logic                    zero_norm;
	logic                    too_long;
	modport source (output valid, similarity, zero_norm, too_long, input ready);
	modport sink (input valid, similarity, zero_norm, too_long, output ready);
endinterface

// ===== hw/rtl/csim_front.sv =====
module csim_front (
	input  logic           clk,
	input  logic           arst_n,
	csim_in_if.sink        elems,
	input  logic           fifo_full,
	output logic           push,
	output csim_pkg::job_t push_job
);
	import csim_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);

	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_inc;
	logic                     accept;
	logic                     adv;
	logic                     s1_valid_q;
	logic                     s1_last_q;
	logic                     s1_en_s1;
	logic                     s1_long_s1;
	logic signed [PROD_W-1:0] dot_p_s1;
	logic signed [PROD_W-1:0] na_p_s1;
	logic signed [PROD_W-1:0] nb_p_s1;
	logic signed [SUM_W-1:0]  dot_sum_q;
	logic signed [SUM_W-1:0]  na_sum_q;
	logic signed [SUM_W-1:0]  nb_sum_q;
	logic signed [SUM_W-1:0]  dot_next;
	logic signed [SUM_W-1:0]  na_next;
	logic signed [SUM_W-1:0]  nb_next;

	// stall only when a last request waits for a full queue
	assign adv         = s1_valid_q && !(s1_last_q && fifo_full);
	assign elems.ready = !(s1_valid_q && s1_last_q && fifo_full);
	assign accept      = elems.valid && elems.ready;

	// saturating pair count
	assign cnt_inc = (cnt_q <= MAX_CNT) ? cnt_q + CNT_W'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= elems.last ? '0 : cnt_inc;
		end
	end

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_last_q  <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			s1_last_q  <= elems.last;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dot_p_s1   <= elems.elem_a * elems.elem_b;
			na_p_s1    <= elems.elem_a * elems.elem_a;
			nb_p_s1    <= elems.elem_b * elems.elem_b;
			s1_en_s1   <= cnt_inc <= MAX_CNT;
			s1_long_s1 <= cnt_inc > MAX_CNT;
		end
	end

	// stage 2: accumulate, hand off on the last pair
	assign dot_next = dot_sum_q + (s1_en_s1 ? SUM_W'(dot_p_s1) : '0);
	assign na_next  = na_sum_q + (s1_en_s1 ? SUM_W'(na_p_s1) : '0);
	assign nb_next  = nb_sum_q + (s1_en_s1 ? SUM_W'(nb_p_s1) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_sum_q <= '0;
			na_sum_q  <= '0;
			nb_sum_q  <= '0;
		end else if (adv) begin
			if (s1_last_q) begin
				dot_sum_q <= '0;
				na_sum_q  <= '0;
				nb_sum_q  <= '0;
			end else begin
				dot_sum_q <= dot_next;
				na_sum_q  <= na_next;
				nb_sum_q  <= nb_next;
			end
		end
	end

	assign push              = adv && s1_last_q;
	assign push_job.dot      = dot_next;
	assign push_job.norm_a   = na_next;
	assign push_job.norm_b   = nb_next;
	assign push_job.too_long = s1_long_s1;

	// count never passes the saturation point
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT + CNT_W'(1))
		else $error("pair count beyond saturation");

endmodule

// ===== hw/rtl/csim_fifo.sv =====
module csim_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  csim_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output csim_pkg::job_t pop_job
);
	import csim_pkg::*;

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full    = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_job = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// ===== hw/rtl/csim_back.sv =====
module csim_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  csim_pkg::job_t pop_job,
	output logic           pop,
	csim_out_if.source     result
);
	import csim_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQRT = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]              state_q;
	logic [STEP_W-1:0]       step_q;
	logic                    neg_q;
	logic                    long_q;
	logic                    zero_q;
	logic [SUM_W-1:0]        mag_q;
	logic [SUM_W-1:0]        va_q;
	logic [SUM_W-1:0]        vb_q;
	sqrt_t                   sa_q;
	sqrt_t                   sb_q;
	sqrt_t                   sa_nxt;
	sqrt_t                   sb_nxt;
	logic [SUM_W-1:0]        den_q;
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        diff;
	logic                    ge;
	logic [Q_W-1:0]          quo_q;
	logic [Q_W-1:0]          quo_clamp;
	logic signed [SIM_W-1:0] sim_val;
	logic                    out_valid_q;
	logic signed [SIM_W-1:0] out_sim_q;
	logic                    out_zero_q;
	logic                    out_long_q;
	logic                    out_free;
	logic                    job_zero;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign job_zero = (pop_job.norm_a == '0) || (pop_job.norm_b == '0);
	assign out_free = !out_valid_q || result.ready;

	// root digit steps on both norms
	assign sa_nxt = sqrt_step(sa_q, va_q[SUM_W-1 -: 2]);
	assign sb_nxt = sqrt_step(sb_q, vb_q[SUM_W-1 -: 2]);

	// restoring divide step
	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = ge ? rem_q - {1'b0, den_q} : rem_q;

	// clamp and sign
	assign quo_clamp = (quo_q > SIM_ONE) ? SIM_ONE : quo_q;
	assign sim_val   = neg_q ? -SIM_W'(quo_clamp) : SIM_W'(quo_clamp);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						step_q  <= STEP_W'(RT_W - 1);
						state_q <= (pop_job.too_long || job_zero) ? ST_DONE : ST_SQRT;
					end
				end
				ST_SQRT: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					step_q  <= STEP_W'(Q_W - 1);
					state_q <= ({1'b0, mag_q} >= {den_q, 1'b0}) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					neg_q  <= pop_job.dot[SUM_W-1];
					mag_q  <= pop_job.dot[SUM_W-1] ? SUM_W'(-pop_job.dot) : pop_job.dot;
					va_q   <= pop_job.norm_a;
					vb_q   <= pop_job.norm_b;
					sa_q   <= '0;
					sb_q   <= '0;
					long_q <= pop_job.too_long;
					zero_q <= !pop_job.too_long && job_zero;
					quo_q  <= '0;
				end
			end
			ST_SQRT: begin
				sa_q <= sa_nxt;
				sb_q <= sb_nxt;
				va_q <= {va_q[SUM_W-3:0], 2'b00};
				vb_q <= {vb_q[SUM_W-3:0], 2'b00};
			end
			ST_MUL: begin
				den_q <= sa_q.root * sb_q.root;
			end
			ST_CHK: begin
				rem_q <= {1'b0, mag_q};
				quo_q <= SIM_ONE;
			end
			ST_DIV: begin
				rem_q <= {diff[DIV_W-2:0], 1'b0};
				quo_q <= {quo_q[Q_W-2:0], ge};
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_sim_q  <= sim_val;
			out_zero_q <= zero_q;
			out_long_q <= long_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.similarity = out_sim_q;
	assign result.zero_norm  = out_zero_q;
	assign result.too_long   = out_long_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_zero_q && out_long_q))
		else $error("both flags set");

	a_flag_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_zero_q || out_long_q)) |-> (out_sim_q == '0))
		else $error("flagged result with nonzero similarity");

endmodule

// ===== hw/rtl/cosine_similarity_engine.sv =====
// throughput: one element pair per cycle unless a last pair waits on a full queue; the
// queue holds finished sums, so the front end can take the next vector while the back end is busy
// result path: the 24-step square root, one multiply, one range check and the 15-step
// divide; an overshoot skips the divide and a flagged result skips roots and divide
// reset: arst_n clears the sums, pair count, queue and sequencer at once
module cosine_similarity_engine (
	input logic        clk,
	input logic        arst_n,
	csim_in_if.sink    elems,
	csim_out_if.source result
);
	import csim_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t push_job;
	job_t pop_job;

	// accumulate element pairs
	csim_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.elems    (elems),
		.fifo_full(full),
		.push     (push),
		.push_job (push_job)
	);

	// finished sums wait here
	csim_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.pop_job (pop_job)
	);

	// roots, divide and result
	csim_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.pop_job(pop_job),
		.pop    (pop),
		.result (result)
	);

endmodule
